FILE: design/lwbc_pkg.sv
package lwbc_pkg;

  localparam int NumBg     = 4;
  localparam int NumLayers = NumBg + 1;
  localparam int IdxW      = $clog2(NumLayers);
  localparam int KeyW      = 2 + IdxW;

  localparam logic [15:0] AllLayers    = 16'hFFFF;
  localparam logic [5:0]  FlagObj      = 6'h10;
  localparam logic [5:0]  FlagBackdrop = 6'h20;

  typedef logic [14:0] color_t;

  typedef enum logic [1:0] {
    BLEND_OFF   = 2'd0,
    BLEND_ALPHA = 2'd1,
    BLEND_WHITE = 2'd2,
    BLEND_BLACK = 2'd3
  } blend_mode_e;

  typedef enum logic [2:0] {
    REG_DISPLAY_CONTROL = 3'd0,
    REG_BG_PRIORITY     = 3'd1,
    REG_BLEND_CONTROL   = 3'd2,
    REG_BLEND_ALPHA     = 3'd3,
    REG_BLEND_FADE      = 3'd4,
    REG_WINDOW_INSIDE   = 3'd5,
    REG_WINDOW_OUTSIDE  = 3'd6,
    REG_BACKDROP_COLOR  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  display_control;
    logic [7:0]  bg_priority;
    logic [13:0] blend_control;
    logic [12:0] blend_alpha;
    logic [4:0]  blend_fade;
    logic [13:0] window_inside;
    logic [13:0] window_outside;
    color_t      backdrop_color;
  } cfg_t;

  // layer 0 is the sprite, layer b+1 is background b
  typedef struct packed {
    color_t [NumLayers-1:0]           col;
    logic   [NumLayers-1:0]           vis;
    logic   [NumLayers-1:0][KeyW-1:0] key;
    logic                             blend_ok;
    logic                             obj_alpha;
  } layers_t;

  typedef struct packed {
    color_t     col0;
    color_t     col1;
    logic [5:0] flg0;
    logic [5:0] flg1;
    logic       blend_ok;
    logic       obj_alpha;
  } top2_t;

  function automatic logic [4:0] clamp16(input logic [4:0] v);
    return (v > 5'd16) ? 5'd16 : v;
  endfunction

endpackage

FILE: design/layer_window_blend_compositor.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------------------
// pixel in | input     | in_valid_i/in_ready_o | bg_pixels, obj_*, in_window0/1
// pixel out| output    | out_valid_o/out_ready_i | pixel_color
// config   | input     | cfg_valid_i/cfg_ready_o | cfg_addr_i (register index), cfg_data_i
//
// one pixel per clock while out_ready_i is high; the stages are window select, layer
// ranking, blend products, sum and saturate, each ending in a register.
// every stage holds its own valid bit and fills bubbles, so a stalled output
// only stops stages that are occupied; nothing is dropped or repeated.
// reset clears the valid bits and all configuration registers to zero.
// config writes are always taken, one per cycle.
module layer_window_blend_compositor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] bg_pixels_i,
  input  logic [14:0] obj_color_i,
  input  logic        obj_opaque_i,
  input  logic [1:0]  obj_priority_i,
  input  logic        obj_semi_transparent_i,
  input  logic        obj_window_hit_i,
  input  logic        in_window0_i,
  input  logic        in_window1_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] pixel_color_o
);
  import lwbc_pkg::*;

  cfg_t    cfg_q;
  logic    win_valid, win_ready, sort_valid, sort_ready;
  layers_t win_data;
  top2_t   sort_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_DISPLAY_CONTROL: cfg_q.display_control <= cfg_data_i[7:0];
        REG_BG_PRIORITY:     cfg_q.bg_priority     <= cfg_data_i[7:0];
        REG_BLEND_CONTROL:   cfg_q.blend_control   <= cfg_data_i[13:0];
        REG_BLEND_ALPHA:     cfg_q.blend_alpha     <= cfg_data_i[12:0];
        REG_BLEND_FADE:      cfg_q.blend_fade      <= cfg_data_i[4:0];
        REG_WINDOW_INSIDE:   cfg_q.window_inside   <= cfg_data_i[13:0];
        REG_WINDOW_OUTSIDE:  cfg_q.window_outside  <= cfg_data_i[13:0];
        REG_BACKDROP_COLOR:  cfg_q.backdrop_color  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lwbc_window u_window (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg_q),
    .valid_i                (in_valid_i),
    .ready_o                (in_ready_o),
    .bg_pixels_i            (bg_pixels_i),
    .obj_color_i            (obj_color_i),
    .obj_opaque_i           (obj_opaque_i),
    .obj_priority_i         (obj_priority_i),
    .obj_semi_transparent_i (obj_semi_transparent_i),
    .obj_window_hit_i       (obj_window_hit_i),
    .in_window0_i           (in_window0_i),
    .in_window1_i           (in_window1_i),
    .valid_o                (win_valid),
    .ready_i                (win_ready),
    .data_o                 (win_data)
  );

  lwbc_sort u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (win_valid),
    .ready_o (win_ready),
    .data_i  (win_data),
    .valid_o (sort_valid),
    .ready_i (sort_ready),
    .data_o  (sort_data)
  );

  lwbc_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (sort_valid),
    .ready_o       (sort_ready),
    .data_i        (sort_data),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .pixel_color_o (pixel_color_o)
  );

endmodule

FILE: design/lwbc_window.sv
module lwbc_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lwbc_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [63:0]     bg_pixels_i,
  input  logic [14:0]     obj_color_i,
  input  logic            obj_opaque_i,
  input  logic [1:0]      obj_priority_i,
  input  logic            obj_semi_transparent_i,
  input  logic            obj_window_hit_i,
  input  logic            in_window0_i,
  input  logic            in_window1_i,
  output logic            valid_o,
  input  logic            ready_i,
  output lwbc_pkg::layers_t data_o
);
  import lwbc_pkg::*;

  logic      valid_q;
  layers_t   data_d, data_q;
  logic [5:0] win;
  logic [4:0] enabled;
  logic      obj_on;
  logic [15:0] word;

  always_comb begin
    win     = 6'h3F;
    enabled = AllLayers[4:0];
    data_d  = '0;
    data_d.blend_ok = 1'b1;
    // window priority: win0, win1, object window, outside
    if (|cfg_i.display_control[7:5]) begin
      if (cfg_i.display_control[5] && in_window0_i) begin
        win = cfg_i.window_inside[5:0];
      end else if (cfg_i.display_control[6] && in_window1_i) begin
        win = cfg_i.window_inside[13:8];
      end else if (cfg_i.display_control[7] && obj_window_hit_i) begin
        win = cfg_i.window_outside[13:8];
      end else begin
        win = cfg_i.window_outside[5:0];
      end
      enabled = win[4:0];
      data_d.blend_ok = win[5];
    end

    obj_on = obj_opaque_i & cfg_i.display_control[4];
    data_d.obj_alpha = obj_on & obj_semi_transparent_i;
    data_d.vis[0] = obj_on & enabled[4];
    data_d.col[0] = obj_color_i;
    data_d.key[0] = {obj_priority_i, IdxW'(0)};
    word = '0;
    for (int b = 0; b < NumBg; b++) begin
      word = bg_pixels_i[16*b +: 16];
      data_d.vis[b+1] = cfg_i.display_control[b] & enabled[b] & word[15];
      data_d.col[b+1] = word[14:0];
      data_d.key[b+1] = {cfg_i.bg_priority[2*b +: 2], IdxW'(b + 1)};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: design/lwbc_sort.sv
module lwbc_sort (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lwbc_pkg::cfg_t    cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  lwbc_pkg::layers_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lwbc_pkg::top2_t   data_o
);
  import lwbc_pkg::*;

  logic  valid_q;
  top2_t data_d, data_q;
  logic [NumLayers-1:0][IdxW-1:0] rank;
  logic [5:0] flg;

  // keys are unique, so a layer's rank is the count of visible layers ahead of it
  always_comb begin
    rank = '0;
    for (int i = 0; i < NumLayers; i++) begin
      for (int j = 0; j < NumLayers; j++) begin
        if (data_i.vis[j] && (data_i.key[j] < data_i.key[i])) begin
          rank[i] = rank[i] + IdxW'(1);
        end
      end
    end
  end

  always_comb begin
    data_d.col0      = cfg_i.backdrop_color;
    data_d.flg0      = FlagBackdrop;
    data_d.col1      = cfg_i.backdrop_color;
    data_d.flg1      = FlagBackdrop;
    data_d.blend_ok  = data_i.blend_ok;
    data_d.obj_alpha = data_i.obj_alpha;
    flg = '0;
    for (int i = 0; i < NumLayers; i++) begin
      flg = (i == 0) ? FlagObj : 6'(1 << (i - 1));
      if (data_i.vis[i] && rank[i] == IdxW'(0)) begin
        data_d.col0 = data_i.col[i];
        data_d.flg0 = flg;
      end
      if (data_i.vis[i] && rank[i] == IdxW'(1)) begin
        data_d.col1 = data_i.col[i];
        data_d.flg1 = flg;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: design/lwbc_blend.sv
module lwbc_blend (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lwbc_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  lwbc_pkg::top2_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [14:0]     pixel_color_o
);
  import lwbc_pkg::*;

  typedef struct packed {
    blend_mode_e     op;
    color_t          base;
    logic [2:0][8:0] pa;
    logic [2:0][8:0] pb;
    logic [2:0][8:0] pf;
  } prod_t;

  logic        valid3_q, valid4_q, ready3, ready4;
  prod_t       prod_d, prod_q;
  color_t      pix_d, pix_q;
  logic [5:0]  first, second;
  blend_mode_e mode;
  logic        two_layers;
  logic [4:0]  ea, eb, ey, ca, cb, cf, cbase;
  logic [9:0]  sum;
  logic [5:0]  quo;

  // stage 3: pick the operation and form the per-channel products
  always_comb begin
    first      = cfg_i.blend_control[5:0];
    second     = cfg_i.blend_control[13:8];
    mode       = blend_mode_e'(cfg_i.blend_control[7:6]);
    two_layers = data_i.flg0 != FlagBackdrop;
    ea = clamp16(cfg_i.blend_alpha[4:0]);
    eb = clamp16(cfg_i.blend_alpha[12:8]);
    ey = clamp16(cfg_i.blend_fade);

    prod_d.op = BLEND_OFF;
    if (data_i.obj_alpha) begin
      // semi-transparent sprite overrides mode and window blend bit
      if (data_i.flg0 == FlagObj && two_layers && |(data_i.flg1 & second)) begin
        prod_d.op = BLEND_ALPHA;
      end
    end else if (data_i.blend_ok) begin
      case (mode)
        BLEND_ALPHA: begin
          if (|(data_i.flg0 & first) && two_layers && |(data_i.flg1 & second)) begin
            prod_d.op = BLEND_ALPHA;
          end
        end
        BLEND_WHITE, BLEND_BLACK: begin
          if (|(data_i.flg0 & first)) begin
            prod_d.op = mode;
          end
        end
        default: ;
      endcase
    end

    prod_d.base = data_i.col0;
    ca = '0;
    cb = '0;
    cf = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ca = data_i.col0[5*ch +: 5];
      cb = data_i.col1[5*ch +: 5];
      cf = (prod_d.op == BLEND_WHITE) ? (5'd31 - ca) : ca;
      prod_d.pa[ch] = {4'b0, ca} * {4'b0, ea};
      prod_d.pb[ch] = {4'b0, cb} * {4'b0, eb};
      prod_d.pf[ch] = {4'b0, cf} * {4'b0, ey};
    end
  end

  // stage 4: sum, scale and saturate
  always_comb begin
    pix_d = prod_q.base;
    sum   = '0;
    quo   = '0;
    cbase = '0;
    for (int ch = 0; ch < 3; ch++) begin
      cbase = prod_q.base[5*ch +: 5];
      sum   = {1'b0, prod_q.pa[ch]} + {1'b0, prod_q.pb[ch]};
      quo   = sum[9:4];
      case (prod_q.op)
        BLEND_ALPHA: pix_d[5*ch +: 5] = (quo > 6'd31) ? 5'd31 : quo[4:0];
        BLEND_WHITE: pix_d[5*ch +: 5] = cbase + prod_q.pf[ch][8:4];
        BLEND_BLACK: pix_d[5*ch +: 5] = cbase - prod_q.pf[ch][8:4];
        default:     pix_d[5*ch +: 5] = cbase;
      endcase
    end
  end

  assign ready4        = !valid4_q || ready_i;
  assign ready3        = !valid3_q || ready4;
  assign ready_o       = ready3;
  assign valid_o       = valid4_q;
  assign pixel_color_o = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      if (ready3) begin
        valid3_q <= valid_i;
      end
      if (ready4) begin
        valid4_q <= valid3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && valid_i) begin
      prod_q <= prod_d;
    end
    if (ready4 && valid3_q) begin
      pix_q <= pix_d;
    end
  end

endmodule
